### rtl/assert_macros.svh
// Assertion macros for the checker file of this block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/frbc_pkg.sv
// Constants, types and helper functions for the free-run bit counter.
// No dependencies; every other file of the block but assert_macros.svh refers to it by scoped names.
package frbc_pkg;

	localparam int BYTE_W    = 8;
	localparam int ZERO_W    = 4;
	localparam int CNT_W     = 16;
	localparam int MAX_BYTES = 4096;

	localparam int CNT_MAX_INT = (1 << CNT_W) - 1;
	localparam int BOUND_INT   = (MAX_BYTES * 8 > CNT_MAX_INT) ? CNT_MAX_INT : MAX_BYTES * 8;

	localparam logic [CNT_W-1:0]  CNT_BOUND = CNT_W'(BOUND_INT);
	localparam logic [CNT_W-1:0]  MIN_RUN   = CNT_W'(BYTE_W);
	localparam logic [ZERO_W-1:0] ALL_ZERO  = ZERO_W'(BYTE_W);

	// Contribution of one byte to the total, handed from the run tracker.
	typedef struct packed {
		logic             valid;
		logic             last;
		logic [CNT_W-1:0] amount;
	} contrib_t;

	function automatic logic [ZERO_W-1:0] lead_zeros(input logic [BYTE_W-1:0] v);
		logic [ZERO_W-1:0] n;
		logic              hit;
		n   = '0;
		hit = 1'b0;
		for (int i = BYTE_W - 1; i >= 0; i--) begin
			if (!hit && !v[i]) begin
				n = n + 1'b1;
			end else begin
				hit = 1'b1;
			end
		end
		return n;
	endfunction

	function automatic logic [ZERO_W-1:0] trail_zeros(input logic [BYTE_W-1:0] v);
		logic [ZERO_W-1:0] n;
		logic              hit;
		n   = '0;
		hit = 1'b0;
		for (int i = 0; i < BYTE_W; i++) begin
			if (!hit && !v[i]) begin
				n = n + 1'b1;
			end else begin
				hit = 1'b1;
			end
		end
		return n;
	endfunction

	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
		input logic [CNT_W-1:0] b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s > {1'b0, CNT_BOUND}) ? CNT_BOUND : s[CNT_W-1:0];
	endfunction

endpackage

### rtl/frbc_if.sv
// Valid/ready channel interfaces for bitmap bytes and count results.
// Depends on frbc_pkg for field widths.
interface frbc_byte_if;
	logic                            valid;
	logic                            ready;
	logic [frbc_pkg::BYTE_W-1:0]     bitmap_byte;
	logic                            last_byte;

	modport source (output valid, output bitmap_byte, output last_byte, input ready);
	modport sink (input valid, input bitmap_byte, input last_byte, output ready);
endinterface

interface frbc_result_if;
	logic                        valid;
	logic                        ready;
	logic [frbc_pkg::CNT_W-1:0]  free_bits;

	modport source (output valid, output free_bits, input ready);
	modport sink (input valid, input free_bits, output ready);
endinterface

### rtl/frbc_run_tracker.sv
// Input register and free-run tracking: turns each byte into a contribution to the total.
// Depends on frbc_pkg.
module frbc_run_tracker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          advance,
	input  logic                          take,
	input  logic [frbc_pkg::BYTE_W-1:0]   bitmap_byte,
	input  logic                          last_byte,
	output frbc_pkg::contrib_t            contrib
);

	logic                          valid_s1;
	logic [frbc_pkg::BYTE_W-1:0]   byte_s1;
	logic                          last_s1;
	logic                          valid_s2;
	logic                          last_s2;
	logic [frbc_pkg::CNT_W-1:0]    amount_s2;

	logic                          run_open_q;
	logic [frbc_pkg::CNT_W-1:0]    run_length_q;

	logic [frbc_pkg::ZERO_W-1:0]   lz;
	logic [frbc_pkg::ZERO_W-1:0]   tz;
	logic [frbc_pkg::CNT_W-1:0]    grown;
	logic                          nxt_open;
	logic [frbc_pkg::CNT_W-1:0]    nxt_len;
	logic [frbc_pkg::CNT_W-1:0]    closed;
	logic [frbc_pkg::CNT_W-1:0]    amount;

	always_comb begin
		lz       = frbc_pkg::lead_zeros(byte_s1);
		tz       = frbc_pkg::trail_zeros(byte_s1);
		grown    = frbc_pkg::sat_add(run_length_q, frbc_pkg::CNT_W'(lz));
		nxt_open = run_open_q;
		nxt_len  = run_length_q;
		closed   = '0;
		if (!run_open_q) begin
			if (tz != '0) begin
				nxt_open = 1'b1;
				nxt_len  = frbc_pkg::sat_add('0, frbc_pkg::CNT_W'(tz));
			end
		end else begin
			nxt_len = grown;
			if (lz != frbc_pkg::ALL_ZERO) begin
				if (grown >= frbc_pkg::MIN_RUN) begin
					closed = grown;
				end
				nxt_open = (tz != '0);
				nxt_len  = frbc_pkg::CNT_W'(tz);
			end
		end
		// A run that closes leaves at most seven trailing zeros open, so a closed run
		// and a flushed run never both count on the same byte.
		if (last_s1 && nxt_open && nxt_len >= frbc_pkg::MIN_RUN) begin
			amount = nxt_len;
		end else begin
			amount = closed;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			run_open_q   <= 1'b0;
			run_length_q <= '0;
		end else if (advance) begin
			valid_s1 <= take;
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				if (last_s1) begin
					run_open_q   <= 1'b0;
					run_length_q <= '0;
				end else begin
					run_open_q   <= nxt_open;
					run_length_q <= nxt_len;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			byte_s1   <= bitmap_byte;
			last_s1   <= last_byte;
			last_s2   <= last_s1;
			amount_s2 <= amount;
		end
	end

	assign contrib = '{valid: valid_s2, last: last_s2, amount: amount_s2};

endmodule

### rtl/free_run_bit_counter.sv
// Free-run bit counter: accepts one bitmap byte per cycle while not stalled and, after the
// byte marked last, offers the total of all free runs of eight bits or more that span
// byte boundaries. The byte goes through an input register, the run tracker and the
// total accumulator; the tracker holds two saturating adds and the accumulator one. A
// held result stalls input only when a further result is ready to take its place.
// Depends on frbc_pkg and frbc_if.
module free_run_bit_counter (
	input  logic                  clk,
	input  logic                  arst_n,
	frbc_byte_if.sink             bitmap,
	frbc_result_if.source         result
);

	frbc_pkg::contrib_t           contrib;
	logic                         advance;
	logic [frbc_pkg::CNT_W-1:0]   running_total_q;
	logic [frbc_pkg::CNT_W-1:0]   sum;
	logic                         out_valid_q;
	logic [frbc_pkg::CNT_W-1:0]   free_bits_q;
	logic                         load;

	// The pipeline only stops when a finished total cannot be moved into the output register.
	assign advance = !(contrib.valid && contrib.last && out_valid_q && !result.ready);
	assign load    = advance && contrib.valid && contrib.last;
	assign sum     = frbc_pkg::sat_add(running_total_q, contrib.amount);

	assign bitmap.ready     = advance;
	assign result.valid     = out_valid_q;
	assign result.free_bits = free_bits_q;

	frbc_run_tracker u_tracker (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.take        (bitmap.valid),
		.bitmap_byte (bitmap.bitmap_byte),
		.last_byte   (bitmap.last_byte),
		.contrib     (contrib)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_total_q <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (advance && contrib.valid) begin
				running_total_q <= contrib.last ? '0 : sum;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			free_bits_q <= sum;
		end
	end

endmodule

### rtl/frbc_checker.sv
// Port-level checks for the free-run bit counter, attached to the top level by bind.
// Depends on frbc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module frbc_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic                        in_last,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic [frbc_pkg::CNT_W-1:0]  free_bits
);

	logic [2:0] pending_q;
	logic       last_in;
	logic       res_out;

	assign last_in = in_valid && in_ready && in_last;
	assign res_out = out_valid && out_ready;

	// Requests marked last that have not yet produced a delivered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (last_in && !res_out) begin
			pending_q <= pending_q + 3'd1;
		end else if (res_out && !last_in) begin
			pending_q <= pending_q - 3'd1;
		end
	end

	`ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(free_bits), "result dropped or changed while stalled")
	`ASSERT_IMPLIES(a_bound, clk, arst_n, out_valid, free_bits <= frbc_pkg::CNT_BOUND, "total above saturation bound")
	`ASSERT_IMPLIES(a_cause, clk, arst_n, out_valid, pending_q != 3'd0, "result without a last byte")
	`ASSERT_IMPLIES(a_depth, clk, arst_n, 1'b1, pending_q <= 3'd3, "more results in flight than stages")
	`ASSERT_IMPLIES(a_stall, clk, arst_n, !in_ready, out_valid && !out_ready, "input stalled without output backpressure")

endmodule

bind free_run_bit_counter frbc_checker u_frbc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (bitmap.valid),
	.in_ready  (bitmap.ready),
	.in_last   (bitmap.last_byte),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.free_bits (result.free_bits)
);

### sim/free_run_bit_counter_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for free_run_bit_counter: streams bitmaps and predicts each total.
// Depends on frbc_pkg and the channel interfaces in frbc_if.sv.

class free_bits_board;
	localparam logic [16:0] BOUND = {1'b0, frbc_pkg::CNT_BOUND};

	logic        run_open;
	logic [15:0] run_len;
	logic [15:0] total;
	logic [15:0] totals_due[$];
	int          errors;

	function new();
		run_open = 1'b0;
		run_len  = '0;
		total    = '0;
		errors   = 0;
	endfunction

	function logic [15:0] bounded_sum(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s > BOUND) ? BOUND[15:0] : s[15:0];
	endfunction

	function int zeros_from_msb(input logic [7:0] v);
		int n;
		n = 0;
		while (n < 8 && !v[7 - n])
			n++;
		return n;
	endfunction

	function int zeros_from_lsb(input logic [7:0] v);
		int n;
		n = 0;
		while (n < 8 && !v[n])
			n++;
		return n;
	endfunction

	function void note_byte(input logic [7:0] b, input logic last);
		int lz;
		int tz;
		lz = zeros_from_msb(b);
		tz = zeros_from_lsb(b);
		if (!run_open) begin
			if (tz > 0) begin
				run_open = 1'b1;
				run_len  = bounded_sum(16'd0, 16'(tz));
			end
		end else begin
			run_len = bounded_sum(run_len, 16'(lz));
			// A byte with a set bit closes the run; its trailing zeros start the next one.
			if (lz < 8) begin
				if (run_len >= 16'd8)
					total = bounded_sum(total, run_len);
				run_open = (tz > 0);
				run_len  = 16'(tz);
			end
		end
		if (last) begin
			if (run_open && run_len >= 16'd8)
				total = bounded_sum(total, run_len);
			totals_due.push_back(total);
			run_open = 1'b0;
			run_len  = '0;
			total    = '0;
		end
	endfunction

	function void check_total(input logic [15:0] got);
		logic [15:0] want;
		if (totals_due.size() == 0) begin
			$error("free_bits: expected none, actual %0d", got);
			errors++;
		end else begin
			want = totals_due.pop_front();
			if (got !== want) begin
				$error("free_bits: expected %0d, actual %0d", want, got);
				errors++;
			end
		end
	endfunction

	function int waiting();
		return totals_due.size();
	endfunction
endclass

module free_run_bit_counter_test;
	localparam int CYCLE_LIMIT = 300000;
	localparam int SETTLE_CYCLES = 10;

	logic clk;
	logic arst_n;

	frbc_byte_if   bitmap_ch();
	frbc_result_if result_ch();

	free_run_bit_counter uut (
		.clk    (clk),
		.arst_n (arst_n),
		.bitmap (bitmap_ch),
		.result (result_ch)
	);

	free_bits_board board;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_ask;
	int hold_left;
	int cycle_count;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		clk                   = 1'b0;
		arst_n                = 1'b0;
		bitmap_ch.valid       = 1'b0;
		bitmap_ch.bitmap_byte = '0;
		bitmap_ch.last_byte   = 1'b0;
		result_ch.ready       = 1'b0;
		send_idle_pct         = 0;
		recv_stall_pct        = 0;
		hold_ask              = 0;
		hold_left             = 0;
		cycle_count           = 0;
		board                 = new();
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Receiver: random stalls, plus a long hold-off counted here when one is asked for.
	always @(posedge clk) begin
		if (hold_ask > 0) begin
			hold_left = hold_ask;
			hold_ask  = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (bitmap_ch.valid && bitmap_ch.ready)
				board.note_byte(bitmap_ch.bitmap_byte, bitmap_ch.last_byte);
			if (result_ch.valid && result_ch.ready)
				board.check_total(result_ch.free_bits);
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			bitmap_ch.valid <= 1'b0;
			@(posedge clk);
		end
		bitmap_ch.valid       <= 1'b1;
		bitmap_ch.bitmap_byte <= b;
		bitmap_ch.last_byte   <= last;
		do
			@(posedge clk);
		while (!bitmap_ch.ready);
	endtask

	// Valid is dropped first, and the wait for due totals begins once the monitor has noted the final request.
	task automatic drain();
		bitmap_ch.valid <= 1'b0;
		@(posedge clk);
		while (board.waiting() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_byte();
		logic [7:0] r;
		r = 8'($urandom);
		case ($urandom_range(9))
			0, 1, 2: return 8'h00;
			3:       return 8'hFF;
			4:       return r >> $urandom_range(7);
			5:       return r << $urandom_range(7);
			6:       return 8'h01 << $urandom_range(7);
			default: return r;
		endcase
	endfunction

	task automatic send_random_bitmap(output int sent);
		int len;
		len = ($urandom_range(9) == 0) ? $urandom_range(64, 13) : $urandom_range(12, 1);
		for (int i = 0; i < len; i++)
			send_byte(pick_byte(), i == len - 1);
		sent = len;
	endtask

	task automatic send_list(input logic [7:0] bytes[$]);
		foreach (bytes[i])
			send_byte(bytes[i], i == bytes.size() - 1);
	endtask

	initial begin
		int count;
		int sent;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Single-byte bitmaps: all free, all used, a lone set bit at each end, an inner gap.
		send_list('{8'h00});
		send_list('{8'hFF});
		send_list('{8'h01});
		send_list('{8'h80});
		send_list('{8'h81});
		// Boundary runs: 3 + 3 is too short, 4 + 4 just counts, 7 + 7 counts.
		send_list('{8'hF8, 8'h1F});
		send_list('{8'hF0, 8'h0F});
		send_list('{8'h80, 8'h01});
		// Whole zero bytes inside a run, then a zero byte opening one with no run open.
		send_list('{8'h80, 8'h00, 8'h00, 8'h01});
		send_list('{8'hFF, 8'h00, 8'h00, 8'h7F});
		send_list('{8'h7E, 8'h00, 8'h42, 8'h00});
		drain();

		// Run length saturation on a stream longer than the bitmap bound, then a short
		// run closed onto the saturated total.
		for (int i = 0; i < 4100; i++)
			send_byte(8'h00, 1'b0);
		send_byte(8'h81, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		drain();

		// The receiver holds off for a long stretch while single-byte requests keep coming.
		hold_ask = 300;
		for (int i = 0; i < 40; i++)
			send_byte(pick_byte(), 1'b1);
		drain();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
				default: begin send_idle_pct = 15; recv_stall_pct = 15; end
			endcase
			count = 0;
			while (count < 400) begin
				send_random_bitmap(sent);
				count += sent;
			end
			drain();
		end

		if (board.waiting() != 0) begin
			$error("free_bits: %0d expected results never arrived", board.waiting());
			board.errors++;
		end
		if (board.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
